// ===== rtl/core/ps2mct_pkg.sv =====
package ps2mct_pkg;

    localparam int X_SUBSTEPS = 4;
    localparam int Y_SUBSTEPS = 8;

    localparam int COLS_W  = 8;
    localparam int ROWS_W  = 6;
    localparam int POS_X_W = 10;
    localparam int POS_Y_W = 9;
    // signed sum of a position and a nine-bit move
    localparam int SUM_W   = 12;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_FIELDS_W = COLS_W + ROWS_W + 3;

    localparam logic [7:0] ACK_BYTE = 8'hFA;

    localparam int FLAG_LEFT       = 0;
    localparam int FLAG_RIGHT      = 1;
    localparam int FLAG_MIDDLE     = 2;
    localparam int FLAG_ALWAYS_ONE = 3;
    localparam int FLAG_X_SIGN     = 4;
    localparam int FLAG_Y_SIGN     = 5;
    localparam int FLAG_X_OVF      = 6;
    localparam int FLAG_Y_OVF      = 7;

    localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd25;

    typedef enum logic [0:0] {
        REG_SCREEN_COLS = 1'b0,
        REG_SCREEN_ROWS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_FLAGS = 3'b001,
        PH_DX    = 3'b010,
        PH_DY    = 3'b100
    } phase_t;

    // clamp v to [0, limit-1]; zero limit gives zero
    function automatic logic [POS_X_W-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v,
        input logic [POS_X_W-1:0] limit
    );
        logic [POS_X_W-1:0] res;
        if (v < 0 || limit == '0)
            res = '0;
        else if ($unsigned(v) >= {{(SUM_W-POS_X_W){1'b0}}, limit})
            res = limit - 1'b1;
        else
            res = v[POS_X_W-1:0];
        return res;
    endfunction

endpackage

// ===== rtl/core/ps2_mouse_packet_cursor_tracker.sv =====
// Channel  | Dir | Handshake            | Payload
// s_*      | in  | s_tvalid / s_tready  | s_tdata[7:0] rx_byte
// m_*      | out | m_tvalid / m_tready  | m_tdata[23:0] packed cursor and buttons
// cfg_*    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle sustained while the result side does not stall.
// A Y byte passes through the input register and then the result register before
// its result shows on m_tvalid and m_tdata.
// Reset clears phase, flags, position and loads 80 columns by 25 rows.
// A stalled result holds in the output register; the input register takes one
// more byte and then holds it, with s_tready low, until the result moves on.
module ps2_mouse_packet_cursor_tracker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [ps2mct_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] cursor_col, [13:8] cursor_row, [14] left_pressed,
    // [15] right_pressed, [16] middle_pressed, [23:17] zero
    output logic [ps2mct_pkg::OUT_TDATA_W-1:0] m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                                     in_valid_reg;
    logic [7:0]                               in_byte_reg;
    logic                                     advance;

    ps2mct_pkg::phase_t                       phase_reg, phase_next;
    logic [7:0]                               flags_reg, flags_next;
    logic [7:0]                               dx_reg, dx_next;
    logic [ps2mct_pkg::POS_X_W-1:0]           pos_x_reg, pos_x_next;
    logic [ps2mct_pkg::POS_Y_W-1:0]           pos_y_reg, pos_y_next;
    logic [ps2mct_pkg::COLS_W-1:0]            cols_reg;
    logic [ps2mct_pkg::ROWS_W-1:0]            rows_reg;

    logic                                     out_valid_reg, out_valid_next;
    logic [ps2mct_pkg::OUT_FIELDS_W-1:0]      out_data_reg, out_data_next;

    logic signed [ps2mct_pkg::SUM_W-1:0]      move_x, move_y, sum_x, sum_y;
    logic [ps2mct_pkg::POS_X_W-1:0]           limit_x, limit_y, clamp_x, clamp_y;
    logic [ps2mct_pkg::POS_X_W-1:0]           col_full;
    logic [ps2mct_pkg::POS_Y_W-1:0]           row_full;
    logic                                     emit;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ps2mct_pkg::OUT_TDATA_W-ps2mct_pkg::OUT_FIELDS_W){1'b0}},
                       out_data_reg};

    // nine-bit sign extension from the flag sign bits
    assign move_x = {{(ps2mct_pkg::SUM_W-8){flags_reg[ps2mct_pkg::FLAG_X_SIGN]}}, dx_reg};
    assign move_y = {{(ps2mct_pkg::SUM_W-8){flags_reg[ps2mct_pkg::FLAG_Y_SIGN]}},
                     in_byte_reg};
    assign sum_x  = $signed({{(ps2mct_pkg::SUM_W-ps2mct_pkg::POS_X_W){1'b0}}, pos_x_reg})
                    + move_x;
    assign sum_y  = $signed({{(ps2mct_pkg::SUM_W-ps2mct_pkg::POS_Y_W){1'b0}}, pos_y_reg})
                    - move_y;

    assign limit_x = ps2mct_pkg::POS_X_W'({2'b00, cols_reg} * ps2mct_pkg::X_SUBSTEPS);
    assign limit_y = ps2mct_pkg::POS_X_W'({4'b0000, rows_reg} * ps2mct_pkg::Y_SUBSTEPS);
    assign clamp_x = ps2mct_pkg::clamp_axis(sum_x, limit_x);
    assign clamp_y = ps2mct_pkg::clamp_axis(sum_y, limit_y);

    assign col_full = ps2mct_pkg::POS_X_W'(pos_x_next / ps2mct_pkg::X_SUBSTEPS);
    assign row_full = ps2mct_pkg::POS_Y_W'(pos_y_next / ps2mct_pkg::Y_SUBSTEPS);

    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        dx_next    = dx_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        emit       = 1'b0;
        if (in_valid_reg && advance)
        begin
            unique case (phase_reg)
                ps2mct_pkg::PH_DX:
                begin
                    dx_next    = in_byte_reg;
                    phase_next = ps2mct_pkg::PH_DY;
                end
                ps2mct_pkg::PH_DY:
                begin
                    pos_x_next = clamp_x;
                    pos_y_next = clamp_y[ps2mct_pkg::POS_Y_W-1:0];
                    phase_next = ps2mct_pkg::PH_FLAGS;
                    emit       = 1'b1;
                end
                default:
                begin
                    phase_next = ps2mct_pkg::PH_FLAGS;
                    // ack is skipped; bad flags byte is dropped alone
                    if (in_byte_reg != ps2mct_pkg::ACK_BYTE
                        && in_byte_reg[ps2mct_pkg::FLAG_ALWAYS_ONE]
                        && !in_byte_reg[ps2mct_pkg::FLAG_X_OVF]
                        && !in_byte_reg[ps2mct_pkg::FLAG_Y_OVF])
                    begin
                        flags_next = in_byte_reg;
                        phase_next = ps2mct_pkg::PH_DX;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {flags_reg[ps2mct_pkg::FLAG_MIDDLE],
                              flags_reg[ps2mct_pkg::FLAG_RIGHT],
                              flags_reg[ps2mct_pkg::FLAG_LEFT],
                              row_full[ps2mct_pkg::ROWS_W-1:0],
                              col_full[ps2mct_pkg::COLS_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ps2mct_pkg::PH_FLAGS;
            flags_reg     <= '0;
            dx_reg        <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            cols_reg      <= ps2mct_pkg::COLS_RESET;
            rows_reg      <= ps2mct_pkg::ROWS_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            dx_reg        <= dx_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ps2mct_pkg::REG_SCREEN_COLS: cols_reg <= cfg_data;
                    ps2mct_pkg::REG_SCREEN_ROWS: rows_reg <= cfg_data[ps2mct_pkg::ROWS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/core/ps2mct_checker.sv =====
module ps2mct_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [ps2mct_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[ps2mct_pkg::OUT_TDATA_W-1:ps2mct_pkg::OUT_FIELDS_W] == '0)
        else $error("nonzero pad bits in result");

    // clamped position never reaches the top cell codes
    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] != 8'hFF && m_tdata[13:8] != 6'h3F)
        else $error("cursor cell out of range");

    // a fresh result follows a byte taken into the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding byte");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_ps2mct_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] col;
        logic [5:0] row;
        logic       left;
        logic       right;
        logic       middle;
    } cursor_report_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;          // [7:0] rx_byte

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] cursor_col, [13:8] cursor_row, [14] left, [15] right, [16] middle
    logic [23:0] m_tdata;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = ps2mct_pkg::REG_SCREEN_COLS;
    logic [7:0]  cfg_data = '0;

    // when set, neither side inserts gaps
    logic        no_gaps = 1'b0;
    int          error_count = 0;

    // cursor tracking state mirrored by the testbench
    ps2mct_pkg::phase_t tracker_phase = ps2mct_pkg::PH_FLAGS;
    logic [7:0]  tracker_flags = '0;
    logic [7:0]  tracker_dx = '0;
    logic [9:0]  tracker_x = '0;
    logic [8:0]  tracker_y = '0;
    logic [7:0]  tracker_cols = ps2mct_pkg::COLS_RESET;
    logic [5:0]  tracker_rows = ps2mct_pkg::ROWS_RESET;

    cursor_report_t pending_cursor[$];

    ps2_mouse_packet_cursor_tracker u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("%0t ns: MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int limit_axis(input int v, input int span);
        if (v < 0 || span == 0)
            return 0;
        if (v >= span)
            return span - 1;
        return v;
    endfunction

    function automatic int move_of(input logic [7:0] value, input logic negative);
        return negative ? int'(value) - 256 : int'(value);
    endfunction

    task automatic track_mouse_byte(input logic [7:0] value);
        cursor_report_t rep;
        int nx;
        int ny;
        case (tracker_phase)
            ps2mct_pkg::PH_DX:
            begin
                tracker_dx = value;
                tracker_phase = ps2mct_pkg::PH_DY;
            end
            ps2mct_pkg::PH_DY:
            begin
                nx = int'(tracker_x)
                     + move_of(tracker_dx, tracker_flags[ps2mct_pkg::FLAG_X_SIGN]);
                ny = int'(tracker_y)
                     - move_of(value, tracker_flags[ps2mct_pkg::FLAG_Y_SIGN]);
                tracker_x = 10'(limit_axis(nx, int'(tracker_cols) * ps2mct_pkg::X_SUBSTEPS));
                tracker_y = 9'(limit_axis(ny, int'(tracker_rows) * ps2mct_pkg::Y_SUBSTEPS));
                tracker_phase = ps2mct_pkg::PH_FLAGS;
                rep.col    = 8'(tracker_x / ps2mct_pkg::X_SUBSTEPS);
                rep.row    = 6'(tracker_y / ps2mct_pkg::Y_SUBSTEPS);
                rep.left   = tracker_flags[ps2mct_pkg::FLAG_LEFT];
                rep.right  = tracker_flags[ps2mct_pkg::FLAG_RIGHT];
                rep.middle = tracker_flags[ps2mct_pkg::FLAG_MIDDLE];
                pending_cursor.push_back(rep);
            end
            default:
            begin
                tracker_phase = ps2mct_pkg::PH_FLAGS;
                // acks and malformed flags bytes are dropped here
                if (value != ps2mct_pkg::ACK_BYTE && value[ps2mct_pkg::FLAG_ALWAYS_ONE]
                    && !value[ps2mct_pkg::FLAG_X_OVF] && !value[ps2mct_pkg::FLAG_Y_OVF])
                begin
                    tracker_flags = value;
                    tracker_phase = ps2mct_pkg::PH_DX;
                end
            end
        endcase
    endtask

    // valid is left high after the handshake; the next call lowers it only for a gap, wait_idle always
    task automatic send_mouse_byte(input logic [7:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        track_mouse_byte(value);
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_mouse_byte(flags);
        send_mouse_byte(dx);
        send_mouse_byte(dy);
    endtask

    task automatic write_screen_reg(input ps2mct_pkg::cfg_reg_t idx,
                                    input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == ps2mct_pkg::REG_SCREEN_COLS)
            tracker_cols = value;
        else
            tracker_rows = value[5:0];
    endtask

    // only called with the block idle
    task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
        write_screen_reg(ps2mct_pkg::REG_SCREEN_COLS, cols);
        write_screen_reg(ps2mct_pkg::REG_SCREEN_ROWS, rows);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle;
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (pending_cursor.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_cursor.size() != 0)
        begin
            report_error($sformatf("%0d results never arrived", pending_cursor.size()));
            pending_cursor.delete();
        end
        // a trailing flags or X byte may still sit in the input register
        repeat (6) @(posedge clk);
    endtask

    task automatic test_packet_decoding;
        send_mouse_byte(ps2mct_pkg::ACK_BYTE);
        send_mouse_byte(8'h00);                 // always-one bit missing
        send_mouse_byte(8'h48);                 // X overflow
        send_mouse_byte(8'h88);                 // Y overflow
        send_mouse_byte(8'hC8);
        send_packet(8'h0F, 8'h7F, 8'h7F);       // all buttons, y pinned at top
        send_packet(8'h38, 8'h80, 8'h80);       // both moves negative
        // ack value as movement data
        send_packet(8'h08, ps2mct_pkg::ACK_BYTE, ps2mct_pkg::ACK_BYTE);
        send_packet(8'h2B, 8'h00, 8'h80);
        send_packet(8'h3F, 8'hFF, 8'hFF);
        wait_idle();
    endtask

    task automatic test_screen_extremes;
        set_screen(8'd255, 8'd63);
        repeat (8) send_packet(8'h28, 8'h7F, 8'h80);  // drive to bottom-right corner
        wait_idle();
        // shrink: position is clamped when the next packet completes
        set_screen(8'd1, 8'd1);
        send_packet(8'h0C, 8'h00, 8'h00);
        wait_idle();
        // zero columns, row data above six bits
        set_screen(8'd0, 8'hFF);
        send_packet(8'h29, 8'h7F, 8'h80);
        wait_idle();
    endtask

    function automatic logic [7:0] pick_move();
        case ($urandom_range(0, 19))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_cols();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random_traffic;
        int sent;
        int seg_end;
        int pick;
        logic [7:0] f;
        sent = 0;
        while (sent < 600)
        begin
            wait_idle();
            set_screen(pick_cols(), 8'($urandom_range(0, 255)));
            no_gaps = ($urandom_range(0, 3) == 0);
            seg_end = sent + 100;
            while (sent < seg_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    f = 8'($urandom_range(0, 255));
                    f[ps2mct_pkg::FLAG_ALWAYS_ONE] = 1'b1;
                    f[ps2mct_pkg::FLAG_X_OVF] = 1'b0;
                    f[ps2mct_pkg::FLAG_Y_OVF] = 1'b0;
                    send_packet(f, pick_move(), pick_move());
                    sent += 3;
                end
                else if (pick < 88)
                begin
                    send_mouse_byte(ps2mct_pkg::ACK_BYTE);
                    sent++;
                end
                else
                begin
                    // noise; may well start or break a packet
                    f = 8'($urandom_range(0, 255));
                    send_mouse_byte(f);
                    sent++;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // result side stalls
    initial
    begin
        int stall;
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        cursor_report_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_cursor.size() == 0)
                report_error($sformatf("unexpected result tdata=%h", m_tdata));
            else
            begin
                want = pending_cursor.pop_front();
                if (m_tdata[7:0] !== want.col)
                    report_error($sformatf("cursor_col expected %0d got %0d",
                                           want.col, m_tdata[7:0]));
                if (m_tdata[13:8] !== want.row)
                    report_error($sformatf("cursor_row expected %0d got %0d",
                                           want.row, m_tdata[13:8]));
                if (m_tdata[14] !== want.left)
                    report_error($sformatf("left_pressed expected %b got %b",
                                           want.left, m_tdata[14]));
                if (m_tdata[15] !== want.right)
                    report_error($sformatf("right_pressed expected %b got %b",
                                           want.right, m_tdata[15]));
                if (m_tdata[16] !== want.middle)
                    report_error($sformatf("middle_pressed expected %b got %b",
                                           want.middle, m_tdata[16]));
                if (m_tdata[23:17] !== '0)
                    report_error($sformatf("tdata padding not zero: %h", m_tdata[23:17]));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_packet_decoding();
        test_screen_extremes();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ps2mct_pkg.sv
rtl/core/ps2_mouse_packet_cursor_tracker.sv
rtl/core/ps2mct_checker.sv
tb/sv/testbench.sv
